FILE: hw/rtl/ilist_pkg.sv
`default_nettype none
package ilist_pkg;

   localparam int DEPTH      = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int WORD_W     = 64;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int GRP_SEL_W  = 3;
   localparam int GROUP_SIZE = 1 << GRP_SEL_W;
   localparam int GROUPS     = DEPTH / GROUP_SIZE;
   localparam int GRP_NUM_W  = IDX_W - GRP_SEL_W;

   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CNT_W-1:0]  position;
      logic [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    found_position;
      logic [WORD_W-1:0]   read_word;
      logic [CNT_W-1:0]    entry_count;
      logic                list_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_WRITE
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type       op;
      logic [CNT_W-1:0]  position;
      logic [CNT_W-1:0]  count;
      logic [WORD_W-1:0] word;
   } cell_ctl_type;

   typedef struct packed {
      logic              match;
      logic [WORD_W-1:0] sel_word;
   } cell_out_type;

   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  index;
      logic [WORD_W-1:0] word;
   } reduce_type;

endpackage
`default_nettype wire

FILE: hw/rtl/indexed_list_insert_delete_engine_unit.sv
`default_nettype none
// Indexed list engine: an ordered list of up to 64 words of 64 bits with an
// entry count, held in a chain of cells that each keep one word.
// Request channel: req_item (kind, position, value) is taken at a rising edge
// where start is high and busy is low. Kinds: insert, remove, find, read,
// update; other codes change nothing and answer ok.
// Response channel: rsp_item is shown for one cycle with rsp_strobe high and
// must be taken in that cycle; there is no back-pressure.
// Steps: in the apply step every cell applies the shift or write at once
// while the cells compare against the key; in the reduce step the first match
// and the read word are resolved through a two-level registered tree of
// groups of eight cells, and the response is registered.
// A new request is not taken while one is in progress: busy stays high from
// the request edge until the response is shown, and a new request may be
// taken at the edge that ends the response cycle.
// Reset empties the list and clears any pending request; word storage is
// not cleared, as entries at or above the count are never read.
module indexed_list_insert_delete_engine_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire ilist_pkg::req_type req_item,
   output logic               rsp_strobe,
   output ilist_pkg::rsp_type rsp_item
);
   import ilist_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_APPLY,
      S_REDUCE
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   cell_ctl_type       cell_ctl;
   cell_op_type        op_in;
   cell_out_type       cell_out [DEPTH];
   logic [WORD_W-1:0]  cell_word [DEPTH];
   reduce_type         reduce_res;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // decide the operation against the count before the request
   always_comb begin
      op_in     = CELL_HOLD;
      status_in = ST_OK;
      count_in  = count_ff;
      case (req_ff.kind)
         KIND_INSERT: begin
            if (req_ff.position > count_ff) begin
               status_in = ST_BAD_POS;
            end else if (count_ff >= CNT_W'(DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               op_in    = CELL_SHIFT_UP;
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (req_ff.position >= count_ff) begin
               status_in = ST_BAD_POS;
            end else begin
               op_in    = CELL_SHIFT_DOWN;
               count_in = count_ff - CNT_W'(1);
            end
         end
         KIND_READ: begin
            if (req_ff.position >= count_ff) begin
               status_in = ST_BAD_POS;
            end
         end
         KIND_UPDATE: begin
            if (req_ff.position >= count_ff) begin
               status_in = ST_BAD_POS;
            end else begin
               op_in = CELL_WRITE;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // drive the chain only in the apply cycle; hold otherwise
   always_comb begin
      cell_ctl.op       = (state_ff == S_APPLY) ? op_in : CELL_HOLD;
      cell_ctl.position = req_ff.position;
      cell_ctl.count    = count_ff;
      cell_ctl.word     = req_ff.value;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      ilist_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(g)),
         .ctl        (cell_ctl),
         .lower_word (cell_word[(g == 0) ? 0 : g - 1]),
         .upper_word (cell_word[(g == DEPTH - 1) ? g : g + 1]),
         .word       (cell_word[g]),
         .cell_out   (cell_out[g])
      );
   end

   ilist_reduce u_reduce (
      .clock    (clock),
      .cell_out (cell_out),
      .result   (reduce_res)
   );

   // assemble the response from the tree and the registered status
   always_comb begin
      rsp_in.status         = status_ff;
      rsp_in.found_position = '0;
      rsp_in.read_word      = '0;
      rsp_in.entry_count    = count_ff;
      rsp_in.list_empty     = (count_ff == '0);
      case (req_ff.kind)
         KIND_FIND: begin
            if (reduce_res.hit) begin
               rsp_in.status         = ST_OK;
               rsp_in.found_position = reduce_res.index;
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         KIND_READ: begin
            if (status_ff == ST_OK) begin
               rsp_in.read_word = reduce_res.word;
            end
         end
         default: begin
            rsp_in.status = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               status_ff <= status_in;
               count_ff  <= count_in;
               state_ff  <= S_REDUCE;
            end
            S_REDUCE: begin
               rsp_ff        <= rsp_in;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_rsp_after_request: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_strobe)
      else $error("response missing two cycles after request");

   a_strobe_from_reduce: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_REDUCE))
      else $error("response strobe outside reduce step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond capacity");

   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == ST_FULL |-> rsp_item.entry_count == CNT_W'(DEPTH))
      else $error("full status with spare capacity");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_APPLY |=> count_ff == $past(count_ff))
      else $error("count changed outside apply step");

endmodule
`default_nettype wire

FILE: hw/rtl/ilist_cell.sv
`default_nettype none
module ilist_cell (
   input  wire                         clock,
   input  wire [ilist_pkg::IDX_W-1:0]  cell_index,
   input  wire ilist_pkg::cell_ctl_type ctl,
   input  wire [ilist_pkg::WORD_W-1:0] lower_word,
   input  wire [ilist_pkg::WORD_W-1:0] upper_word,
   output logic [ilist_pkg::WORD_W-1:0] word,
   output ilist_pkg::cell_out_type     cell_out
);
   import ilist_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic [CNT_W-1:0]  idx_ext;

   assign idx_ext = {1'b0, cell_index};
   assign word    = word_ff;

   always_comb begin
      word_in = word_ff;
      case (ctl.op)
         CELL_SHIFT_UP: begin
            if (idx_ext == ctl.position) begin
               word_in = ctl.word;
            end else if (idx_ext > ctl.position) begin
               word_in = lower_word;
            end
         end
         CELL_SHIFT_DOWN: begin
            if (idx_ext >= ctl.position) begin
               word_in = upper_word;
            end
         end
         CELL_WRITE: begin
            if (idx_ext == ctl.position) begin
               word_in = ctl.word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // only live entries may match a key
   assign cell_out.match    = (idx_ext < ctl.count) && (word_ff == ctl.word);
   assign cell_out.sel_word = (idx_ext == ctl.position) ? word_ff : '0;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/ilist_reduce.sv
`default_nettype none
module ilist_reduce (
   input  wire                      clock,
   input  wire ilist_pkg::cell_out_type cell_out [ilist_pkg::DEPTH],
   output ilist_pkg::reduce_type    result
);
   import ilist_pkg::*;

   logic                 grp_hit_ff  [GROUPS];
   logic [GRP_SEL_W-1:0] grp_idx_ff  [GROUPS];
   logic [WORD_W-1:0]    grp_word_ff [GROUPS];
   logic                 grp_hit_in  [GROUPS];
   logic [GRP_SEL_W-1:0] grp_idx_in  [GROUPS];
   logic [WORD_W-1:0]    grp_word_in [GROUPS];

   // first level: first match and merged word within each group of cells
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_hit_in[g]  = 1'b0;
         grp_idx_in[g]  = '0;
         grp_word_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (cell_out[g*GROUP_SIZE + j].match) begin
               grp_hit_in[g] = 1'b1;
               grp_idx_in[g] = GRP_SEL_W'(j);
            end
            grp_word_in[g] = grp_word_in[g] | cell_out[g*GROUP_SIZE + j].sel_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_hit_ff[g]  <= grp_hit_in[g];
         grp_idx_ff[g]  <= grp_idx_in[g];
         grp_word_ff[g] <= grp_word_in[g];
      end
   end

   // second level: lowest group with a hit wins
   always_comb begin
      result.hit   = 1'b0;
      result.index = '0;
      result.word  = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            result.hit   = 1'b1;
            result.index = {GRP_NUM_W'(g), grp_idx_ff[g]};
         end
         result.word = result.word | grp_word_ff[g];
      end
   end

endmodule
`default_nettype wire
